@@ src/pot_average_dimmer_control_top_assert.svh @@
// Assertion macros for the potentiometer dimmer control block.
// Included by the top level; the macros compile to nothing under SYNTHESIS.
`ifndef POT_AVERAGE_DIMMER_CONTROL_TOP_ASSERT_SVH
`define POT_AVERAGE_DIMMER_CONTROL_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PDC_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pdc assertion failed");

`define PDC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pdc assertion failed");

`else

`define PDC_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define PDC_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ src/pdc_pkg.sv @@
// Shared types and constants for the potentiometer dimmer control block.
// No dependencies.
package pdc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_ADDR_W = 1;

    // Full scale of the converter must be 2**SAMPLE_W - 1 for the level division.
    localparam int ADC_FULL_SCALE = 2**SAMPLE_W - 1;
    localparam int LEVEL_SCALE    = 100;
    localparam int PROD_W         = SAMPLE_W + LEVEL_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_CHANGE_THR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFF_THR    = 1'd1;

    localparam logic [CFG_W-1:0] CHANGE_THR_RESET = 7'd2;
    localparam logic [CFG_W-1:0] OFF_THR_RESET    = 7'd5;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_OFF    = 2'd1,
        ACT_ON_SET = 2'd2,
        ACT_SET    = 2'd3
    } action_t;

endpackage

@@ src/pot_average_dimmer_control_top.sv @@
// Potentiometer dimmer control: moving average over a window of samples, level mapping
// and change-threshold decision. Depends on pdc_pkg and the assertion macro header.
// A result passes through three register stages after its request is accepted:
// window sum, reciprocal divide, level decision. Throughput: one request per cycle while
// m_tready does not stall the output. Reset (aresetn, synchronous, active low) empties the
// pipeline, unprimes the window and restores the register defaults.
`include "pot_average_dimmer_control_top_assert.svh"

module pot_average_dimmer_control_top #(
    parameter int WINDOW_LEN = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_we,
    input  logic [pdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [pdc_pkg::CFG_W-1:0]       cfg_wdata,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [9:0] sample
    input  logic                            s_tuser,   // [0] light_on

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [6:0] level
    output logic [1:0]                      m_tuser    // [1:0] action
);

    localparam int SAMPLE_W = pdc_pkg::SAMPLE_W;
    localparam int LEVEL_W  = pdc_pkg::LEVEL_W;
    localparam int PROD_W   = pdc_pkg::PROD_W;
    localparam int SUM_W    = $clog2(WINDOW_LEN * pdc_pkg::ADC_FULL_SCALE + 1);
    localparam int MUL_W    = 2 * SUM_W;
    // floor(2**SUM_W / WINDOW_LEN) underestimates the quotient by at most one.
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((2**SUM_W) / WINDOW_LEN);
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = LEVEL_W'(pdc_pkg::LEVEL_SCALE);
    localparam logic [SAMPLE_W-1:0] AVG_MAX   = SAMPLE_W'(pdc_pkg::ADC_FULL_SCALE);

    // Configuration registers.
    logic [pdc_pkg::CFG_W-1:0] change_thr_reg;
    logic [pdc_pkg::CFG_W-1:0] off_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            change_thr_reg <= pdc_pkg::CHANGE_THR_RESET;
            off_thr_reg    <= pdc_pkg::OFF_THR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pdc_pkg::CFG_CHANGE_THR: change_thr_reg <= cfg_wdata;
                pdc_pkg::CFG_OFF_THR:    off_thr_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: each stage advances when the one after it can take data.
    logic v1_reg, v2_reg, m_valid_reg;
    logic en_out, en2, en1, accept;

    assign en_out   = !m_valid_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    // Stage 1: window shift line and running sum.
    logic [SAMPLE_W-1:0] sample_in;
    logic [SAMPLE_W-1:0] tap_reg [WINDOW_LEN];
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                primed_reg;
    logic                on1_reg, on2_reg;

    assign sample_in = s_tdata[SAMPLE_W-1:0];

    always_comb begin
        if (primed_reg) begin
            sum_next = sum_reg - SUM_W'(tap_reg[WINDOW_LEN-1]) + SUM_W'(sample_in);
        end else begin
            // The first sample fills the whole window.
            sum_next = SUM_W'(sample_in) * SUM_W'(WINDOW_LEN);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            primed_reg <= 1'b0;
            sum_reg    <= '0;
        end else if (en1) begin
            v1_reg <= accept;
            if (accept) begin
                primed_reg <= 1'b1;
                sum_reg    <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            on1_reg    <= s_tuser;
            tap_reg[0] <= sample_in;
            for (int i = 1; i < WINDOW_LEN; i++) begin
                tap_reg[i] <= primed_reg ? tap_reg[i-1] : sample_in;
            end
        end
    end

    // Stage 2: average by reciprocal multiply with one correction step.
    logic [MUL_W-1:0]    prod;
    logic [SUM_W-1:0]    quot_est, quot_mul, quot_rem, quot;
    logic [SAMPLE_W-1:0] avg_reg;

    always_comb begin
        prod     = MUL_W'(sum_reg) * MUL_W'(RECIP);
        quot_est = prod[MUL_W-1:SUM_W];
        quot_mul = quot_est * SUM_W'(WINDOW_LEN);
        quot_rem = sum_reg - quot_mul;
        quot     = quot_est + SUM_W'(quot_rem >= SUM_W'(WINDOW_LEN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            avg_reg <= quot[SAMPLE_W-1:0];
            on2_reg <= on1_reg;
        end
    end

    // Stage 3: level = avg * 100 / 1023, then the change-threshold decision.
    logic [PROD_W-1:0]   scaled;
    logic [LEVEL_W-1:0]  lvl_est, lvl, diff;
    logic [SAMPLE_W:0]   lvl_rem;
    logic [LEVEL_W-1:0]  last_level_reg;
    logic                take;
    pdc_pkg::action_t    action_next, action_reg;

    always_comb begin
        scaled  = PROD_W'(avg_reg) * PROD_W'(pdc_pkg::LEVEL_SCALE);
        // x / (2**n - 1): start from x >> n; the remainder stays below twice the divisor.
        lvl_est = scaled[PROD_W-1:SAMPLE_W];
        lvl_rem = (SAMPLE_W+1)'(scaled[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(lvl_est);
        lvl     = lvl_est + LEVEL_W'(lvl_rem >= (SAMPLE_W+1)'(pdc_pkg::ADC_FULL_SCALE));
        diff    = (lvl >= last_level_reg) ? (lvl - last_level_reg) : (last_level_reg - lvl);
        take    = diff >= change_thr_reg;
    end

    always_comb begin
        action_next = pdc_pkg::ACT_NONE;
        if (take) begin
            if (lvl < off_thr_reg) begin
                action_next = on2_reg ? pdc_pkg::ACT_OFF : pdc_pkg::ACT_NONE;
            end else begin
                action_next = on2_reg ? pdc_pkg::ACT_SET : pdc_pkg::ACT_ON_SET;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            last_level_reg <= '0;
            action_reg     <= pdc_pkg::ACT_NONE;
        end else if (en_out) begin
            m_valid_reg <= v2_reg;
            if (v2_reg) begin
                action_reg <= action_next;
                if (take) begin
                    last_level_reg <= lvl;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = action_reg;
    assign m_tdata  = {1'b0, last_level_reg};

    logic out_is_off;
    assign out_is_off = m_valid_reg && (action_reg == pdc_pkg::ACT_OFF);

    `PDC_ASSERT_IMPLIES(a_level_range, aclk, aresetn, m_valid_reg, last_level_reg <= LEVEL_MAX)
    `PDC_ASSERT_IMPLIES(a_off_below_thr, aclk, aresetn, out_is_off, last_level_reg < off_thr_reg)
    `PDC_ASSERT_IMPLIES(a_avg_range, aclk, aresetn, v2_reg, avg_reg <= AVG_MAX)
    `PDC_ASSERT_NEXT(a_accept_primes, aclk, aresetn, accept, v1_reg && primed_reg)

endmodule

@@ verif/pot_average_dimmer_control_top_tb.sv @@
// Self-checking testbench for pot_average_dimmer_control_top.
// Depends on pdc_pkg and the top level; predicts each result from its own window model.
`timescale 1ns / 100ps

module pot_average_dimmer_control_top_tb;

    localparam int WIN         = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SAMPLE_W    = pdc_pkg::SAMPLE_W;
    localparam int LEVEL_W     = pdc_pkg::LEVEL_W;
    localparam int FULL_SCALE  = pdc_pkg::ADC_FULL_SCALE;

    typedef struct {
        logic [SAMPLE_W-1:0] smp;
        logic                on;
    } pot_request_t;

    typedef struct {
        pdc_pkg::action_t   act;
        logic [LEVEL_W-1:0] lvl;
    } dimmer_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [pdc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [pdc_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    s_tdata   = '0;   // [9:0] sample
    logic                           s_tuser   = 1'b0; // [0] light_on
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;          // [6:0] level
    logic [1:0]                     m_tuser;          // [1:0] action

    pot_average_dimmer_control_top #(.WINDOW_LEN(WIN)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Window model and register copies.
    logic [SAMPLE_W-1:0] win_ring [WIN];
    int unsigned         win_ptr     = 0;
    int unsigned         win_sum     = 0;
    int unsigned         held_level  = 0;
    bit                  win_primed  = 1'b0;
    int unsigned         thr_change  = pdc_pkg::CHANGE_THR_RESET;
    int unsigned         thr_off     = pdc_pkg::OFF_THR_RESET;

    pot_request_t   pending_q [$];
    dimmer_result_t level_expect_q [$];
    int             queued_total   = 0;
    int             accepted_total = 0;
    int             fail_count     = 0;
    int             cycle_count    = 0;
    int             n_off = 0, n_on_set = 0, n_set = 0, n_none = 0;
    int             n_settings = 1;

    task automatic predict_dimmer(input logic [SAMPLE_W-1:0] smp, input logic on,
                                  output dimmer_result_t res);
        int unsigned avg, lvl, diff;
        int k;
        if (!win_primed) begin
            for (k = 0; k < WIN; k++) win_ring[k] = smp;
            win_sum    = smp * WIN;
            win_primed = 1'b1;
        end
        win_sum           = win_sum - win_ring[win_ptr] + smp;
        win_ring[win_ptr] = smp;
        win_ptr           = (win_ptr + 1) % WIN;
        avg = win_sum / WIN;
        if (avg > FULL_SCALE) avg = FULL_SCALE;
        lvl  = (avg * pdc_pkg::LEVEL_SCALE) / FULL_SCALE;
        diff = (lvl >= held_level) ? lvl - held_level : held_level - lvl;
        res.act = pdc_pkg::ACT_NONE;
        if (diff >= thr_change) begin
            held_level = lvl;
            if (lvl < thr_off) res.act = on ? pdc_pkg::ACT_OFF : pdc_pkg::ACT_NONE;
            else               res.act = on ? pdc_pkg::ACT_SET : pdc_pkg::ACT_ON_SET;
        end
        res.lvl = held_level[LEVEL_W-1:0];
        case (res.act)
            pdc_pkg::ACT_OFF:    n_off++;
            pdc_pkg::ACT_ON_SET: n_on_set++;
            pdc_pkg::ACT_SET:    n_set++;
            default:             n_none++;
        endcase
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        pot_request_t   req;
        dimmer_result_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_dimmer(s_tdata[SAMPLE_W-1:0], s_tuser, res);
                level_expect_q.push_back(res);
                accepted_total++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    req = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, req.smp};
                    s_tuser  <= req.on;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Receiver: checks each result; the stall behavior is redrawn at random on a stall_tick period.
    int stall_mode = 0;
    int stall_tick = 0;

    always @(posedge aclk) begin
        dimmer_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (level_expect_q.size() == 0) begin
                $display("%0t: unexpected result, action %0d level %0d",
                         $time, m_tuser, m_tdata[LEVEL_W-1:0]);
                fail_count++;
            end else begin
                exp_res = level_expect_q.pop_front();
                if (m_tuser !== exp_res.act) begin
                    $display("%0t: action expected %0d, actual %0d", $time, exp_res.act, m_tuser);
                    fail_count++;
                end
                if (m_tdata[LEVEL_W-1:0] !== exp_res.lvl) begin
                    $display("%0t: level expected %0d, actual %0d",
                             $time, exp_res.lvl, m_tdata[LEVEL_W-1:0]);
                    fail_count++;
                end
            end
        end
        stall_tick++;
        if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= stall_tick[0];
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, level_expect_q.size());
            $display("pot_average_dimmer_control_top_tb NOT OK");
            $finish;
        end
    end

    task automatic push_request(input int smp, input int on);
        pot_request_t req;
        req.smp = smp[SAMPLE_W-1:0];
        req.on  = on[0];
        pending_q.push_back(req);
        queued_total++;
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (accepted_total != queued_total || level_expect_q.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pdc_pkg::CFG_ADDR_W-1:0] addr,
                             input int unsigned value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[pdc_pkg::CFG_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == pdc_pkg::CFG_CHANGE_THR) thr_change = value & 32'h7F;
        else                                 thr_off    = value & 32'h7F;
    endtask

    // Mostly a pot turned slowly, with runs slammed between the end stops and some noise.
    task automatic queue_random_requests(input int count);
        int pot_pos, light, mode, run, i;
        pot_pos = $urandom_range(0, FULL_SCALE);
        light   = $urandom_range(0, 1);
        i = 0;
        while (i < count) begin
            mode = $urandom_range(0, 9);
            run  = $urandom_range(4, 30);
            repeat (run) begin
                if (mode < 6) begin
                    pot_pos += $urandom_range(0, 80) - 40;
                    if (pot_pos < 0) pot_pos = 0;
                    if (pot_pos > FULL_SCALE) pot_pos = FULL_SCALE;
                end else if (mode < 8) begin
                    if ($urandom_range(0, 7) == 0) pot_pos = FULL_SCALE - pot_pos;
                    pot_pos = (pot_pos > FULL_SCALE / 2) ? FULL_SCALE : 0;
                end else begin
                    pot_pos = $urandom_range(0, FULL_SCALE);
                end
                if ($urandom_range(0, 9) == 0) light = !light;
                push_request(pot_pos, light);
                i++;
            end
        end
    endtask

    initial begin
        int k, p;
        int unsigned change_set [8] = '{0, 0, 100, 127, 1, 2, 0, 0};
        int unsigned off_set    [8] = '{0, 127, 100, 50, 0, 5, 0, 0};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: priming, end stops, switch-off, already-off, alternating bits.
        push_request(0, 0);
        for (k = 0; k < 8; k++) push_request(FULL_SCALE, k % 2);
        for (k = 0; k < 8; k++) push_request(0, (k < 4) ? 1 : 0);
        push_request(10'h155, 1);
        push_request(10'h2AA, 0);
        push_request(1, 1);
        push_request(FULL_SCALE - 1, 0);
        wait_idle();

        change_set[6] = $urandom_range(0, 127);
        off_set[6]    = $urandom_range(0, 127);
        change_set[7] = $urandom_range(0, 10);
        off_set[7]    = $urandom_range(0, 100);
        for (p = 0; p < 8; p++) begin
            if (p % 2 == 0) begin
                write_reg(pdc_pkg::CFG_CHANGE_THR, change_set[p]);
                write_reg(pdc_pkg::CFG_OFF_THR, off_set[p]);
            end else begin
                write_reg(pdc_pkg::CFG_OFF_THR, off_set[p]);
                write_reg(pdc_pkg::CFG_CHANGE_THR, change_set[p]);
            end
            n_settings++;
            queue_random_requests(125);
            wait_idle();
        end
        repeat (10) @(posedge aclk);

        $display("Ran %0d requests over %0d threshold settings.", accepted_total, n_settings);
        $display("Results: %0d switch-off, %0d switch-on, %0d brightness only, %0d none.",
                 n_off, n_on_set, n_set, n_none);
        if (fail_count == 0) begin
            $display("pot_average_dimmer_control_top_tb OK");
        end else begin
            $display("pot_average_dimmer_control_top_tb NOT OK");
        end
        $finish;
    end

endmodule
